FILE: rtl/fpa_pkg.sv
// Package for the Q24.8 fixed-point ALU: widths, opcodes, error codes,
// pipeline stage record and saturation helpers. No dependencies.
package fpa_pkg;

    localparam int FRAC_BITS     = 8;
    localparam int WORD_W        = 32;
    localparam int KIND_W        = 5;
    localparam int NUM_W         = WORD_W + FRAC_BITS;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_STAGES    = (NUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int NUM_PAD_W     = DIV_STAGES * DIV_STEP_BITS;
    localparam int REM_W         = WORD_W + 1;
    localparam int PROD_W        = 2 * WORD_W + 1;
    localparam int WIDE_W        = NUM_W + 1;

    typedef logic [KIND_W-1:0]       kind_t;
    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [WORD_W-1:0]       uword_t;
    typedef logic [NUM_PAD_W-1:0]    num_t;
    typedef logic [REM_W-1:0]        rem_t;
    typedef logic [PROD_W-1:0]       mag_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_t;

    localparam kind_t OP_ADD      = KIND_W'(0);
    localparam kind_t OP_SUB      = KIND_W'(1);
    localparam kind_t OP_MUL      = KIND_W'(2);
    localparam kind_t OP_DIV      = KIND_W'(3);
    localparam kind_t OP_MIN      = KIND_W'(4);
    localparam kind_t OP_MAX      = KIND_W'(5);
    localparam kind_t OP_INC      = KIND_W'(6);
    localparam kind_t OP_DEC      = KIND_W'(7);
    localparam kind_t OP_NEG      = KIND_W'(8);
    localparam kind_t OP_FROM_INT = KIND_W'(9);
    localparam kind_t OP_TO_INT   = KIND_W'(10);
    localparam kind_t OP_GT       = KIND_W'(11);
    localparam kind_t OP_LT       = KIND_W'(12);
    localparam kind_t OP_GE       = KIND_W'(13);
    localparam kind_t OP_LE       = KIND_W'(14);
    localparam kind_t OP_EQ       = KIND_W'(15);
    localparam kind_t OP_NE       = KIND_W'(16);

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam wide_t WIDE_MAX = {{(WIDE_W-WORD_W){1'b0}}, WORD_MAX};
    localparam wide_t WIDE_MIN = {{(WIDE_W-WORD_W){1'b1}}, WORD_MIN};
    localparam mag_t  MAG_POS_LIMIT = {{(PROD_W-WORD_W){1'b0}}, WORD_MAX};
    localparam mag_t  MAG_NEG_LIMIT = mag_t'(1) << (WORD_W - 1);
    localparam mag_t  ROUND_HALF    = mag_t'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        word_t val;
        logic  cmp;
        err_t  err;
    } res_t;

    typedef struct packed {
        kind_t  kind;
        word_t  a;
        word_t  b;
        logic   neg;
        logic [2*WORD_W-1:0] prod;
        num_t   num;
        rem_t   rem;
        uword_t den;
        mag_t   mag;
        res_t   res;
    } stage_t;

    function automatic res_t sat_wide(input wide_t v);
        res_t r;
        r.cmp = 1'b0;
        r.err = ERR_NONE;
        r.val = word_t'(v[WORD_W-1:0]);
        if (v > WIDE_MAX)
        begin
            r.val = WORD_MAX;
            r.err = ERR_OVERFLOW;
        end
        else if (v < WIDE_MIN)
        begin
            r.val = WORD_MIN;
            r.err = ERR_OVERFLOW;
        end
        return r;
    endfunction

    function automatic res_t sat_mag(input mag_t m, input logic neg);
        res_t r;
        r.cmp = 1'b0;
        r.err = ERR_NONE;
        if (neg)
        begin
            if (m > MAG_NEG_LIMIT)
            begin
                r.val = WORD_MIN;
                r.err = ERR_OVERFLOW;
            end
            else
            begin
                r.val = word_t'(uword_t'(0) - m[WORD_W-1:0]);
            end
        end
        else
        begin
            if (m > MAG_POS_LIMIT)
            begin
                r.val = WORD_MAX;
                r.err = ERR_OVERFLOW;
            end
            else
            begin
                r.val = word_t'(m[WORD_W-1:0]);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/fpa_in_if.sv
// Operation channel of the fixed-point ALU: valid/ready and the operands.
// Depends on fpa_pkg.
interface fpa_in_if;
    logic            valid;
    logic            ready;
    fpa_pkg::kind_t  kind;
    fpa_pkg::word_t  operand_a;
    fpa_pkg::word_t  operand_b;

    modport source (output valid, output kind, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input kind, input operand_a, input operand_b,
                  output ready);
endinterface

FILE: rtl/fpa_out_if.sv
// Result channel of the fixed-point ALU: valid/ready and the result fields.
// Depends on fpa_pkg.
interface fpa_out_if;
    logic           valid;
    logic           ready;
    fpa_pkg::word_t result_value;
    logic           compare_true;
    logic [1:0]     error_code;

    modport source (output valid, output result_value, output compare_true,
                    output error_code, input ready);
    modport sink (input valid, input result_value, input compare_true,
                  input error_code, output ready);
endinterface

FILE: rtl/fpa_div_step.sv
// One pipeline slice of the restoring divider: DIV_STEP_BITS quotient bits.
// Depends on fpa_pkg.
module fpa_div_step (
    input  fpa_pkg::num_t   num_in,
    input  fpa_pkg::rem_t   rem_in,
    input  fpa_pkg::uword_t den,
    output fpa_pkg::num_t   num_out,
    output fpa_pkg::rem_t   rem_out
);
    import fpa_pkg::*;

    num_t num;
    rem_t rem;
    rem_t trial;

    always_comb
    begin
        num   = num_in;
        rem   = rem_in;
        trial = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            trial = {rem[REM_W-2:0], num[NUM_PAD_W-1]};
            num   = {num[NUM_PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, den})
            begin
                trial  = trial - {1'b0, den};
                num[0] = 1'b1;
            end
            rem = trial;
        end
    end

    assign num_out = num;
    assign rem_out = rem;
endmodule

FILE: rtl/fixed_point_q24_8_alu.sv
// Top level of the pipelined Q24.8 fixed-point ALU.
// Depends on fpa_pkg, fpa_in_if, fpa_out_if and fpa_div_step.
//
//   Channel    Direction  Transfer carries
//   operation  in         kind, operand_a, operand_b
//   result     out        result_value, compare_true, error_code
//
// One operation enters per cycle while the skid register is empty; each result
// passes in order through the input register, decode, the restoring divider
// slices, rounding, saturation and the output register.
// Reset clears only the valid bits of the pipeline and output buffer.
// A result that arrives while the output holds one not yet taken goes to a skid
// register, and the pipeline holds while the skid register is full.
module fixed_point_q24_8_alu (
    input logic       clk,
    input logic       rst_n,
    fpa_in_if.sink    operation,
    fpa_out_if.source result
);
    import fpa_pkg::*;

    localparam int LAST = DIV_STAGES + 3;
    localparam int RND  = DIV_STAGES + 2;

    stage_t pipe_reg [0:LAST];
    stage_t pipe_next [0:LAST];
    logic   valid_reg [0:LAST];
    num_t   step_num [0:DIV_STAGES-1];
    rem_t   step_rem [0:DIV_STAGES-1];

    res_t   out_data_reg;
    res_t   skid_data_reg;
    logic   out_valid_reg;
    logic   skid_valid_reg;
    logic   en;

    assign en = !skid_valid_reg;
    assign operation.ready = en;

    wide_t  aw;
    wide_t  bw;
    uword_t mag_a;
    uword_t mag_b;
    logic   round_up;

    always_comb
    begin
        pipe_next[0]      = pipe_reg[0];
        pipe_next[0].kind = operation.kind;
        pipe_next[0].a    = operation.operand_a;
        pipe_next[0].b    = operation.operand_b;
    end

    always_comb
    begin
        pipe_next[1] = pipe_reg[0];
        aw    = {{(WIDE_W-WORD_W){pipe_reg[0].a[WORD_W-1]}}, pipe_reg[0].a};
        bw    = {{(WIDE_W-WORD_W){pipe_reg[0].b[WORD_W-1]}}, pipe_reg[0].b};
        mag_a = pipe_reg[0].a[WORD_W-1] ? uword_t'(0) - uword_t'(pipe_reg[0].a)
                                        : uword_t'(pipe_reg[0].a);
        mag_b = pipe_reg[0].b[WORD_W-1] ? uword_t'(0) - uword_t'(pipe_reg[0].b)
                                        : uword_t'(pipe_reg[0].b);
        pipe_next[1].neg  = pipe_reg[0].a[WORD_W-1] ^ pipe_reg[0].b[WORD_W-1];
        pipe_next[1].prod = mag_a * mag_b;
        pipe_next[1].num  = num_t'({mag_a, {FRAC_BITS{1'b0}}});
        pipe_next[1].rem  = '0;
        pipe_next[1].den  = mag_b;
        pipe_next[1].mag  = '0;
        pipe_next[1].res  = '{val: '0, cmp: 1'b0, err: ERR_NONE};
        unique case (pipe_reg[0].kind)
            OP_ADD:      pipe_next[1].res = sat_wide(aw + bw);
            OP_SUB:      pipe_next[1].res = sat_wide(aw - bw);
            OP_MUL:      pipe_next[1].res.val = '0;
            OP_DIV:
            begin
                if (pipe_reg[0].b == '0)
                begin
                    pipe_next[1].res.err = ERR_DIV_ZERO;
                end
            end
            OP_MIN:      pipe_next[1].res.val = (pipe_reg[0].a < pipe_reg[0].b)
                                                ? pipe_reg[0].a : pipe_reg[0].b;
            OP_MAX:      pipe_next[1].res.val = (pipe_reg[0].a > pipe_reg[0].b)
                                                ? pipe_reg[0].a : pipe_reg[0].b;
            OP_INC:      pipe_next[1].res = sat_wide(aw + wide_t'(1));
            OP_DEC:      pipe_next[1].res = sat_wide(aw - wide_t'(1));
            OP_NEG:      pipe_next[1].res = sat_wide(-aw);
            OP_FROM_INT: pipe_next[1].res = sat_wide(aw <<< FRAC_BITS);
            OP_TO_INT:   pipe_next[1].res.val = pipe_reg[0].a >>> FRAC_BITS;
            OP_GT:       pipe_next[1].res.cmp = pipe_reg[0].a > pipe_reg[0].b;
            OP_LT:       pipe_next[1].res.cmp = pipe_reg[0].a < pipe_reg[0].b;
            OP_GE:       pipe_next[1].res.cmp = pipe_reg[0].a >= pipe_reg[0].b;
            OP_LE:       pipe_next[1].res.cmp = pipe_reg[0].a <= pipe_reg[0].b;
            OP_EQ:       pipe_next[1].res.cmp = pipe_reg[0].a == pipe_reg[0].b;
            OP_NE:       pipe_next[1].res.cmp = pipe_reg[0].a != pipe_reg[0].b;
            default:     pipe_next[1].res.val = '0;
        endcase
    end

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        fpa_div_step u_step (
            .num_in  (pipe_reg[g+1].num),
            .rem_in  (pipe_reg[g+1].rem),
            .den     (pipe_reg[g+1].den),
            .num_out (step_num[g]),
            .rem_out (step_rem[g])
        );

        always_comb
        begin
            pipe_next[g+2]     = pipe_reg[g+1];
            pipe_next[g+2].num = step_num[g];
            pipe_next[g+2].rem = step_rem[g];
            if (g == 0 && pipe_reg[g+1].kind == OP_MUL)
            begin
                pipe_next[g+2].mag = (mag_t'(pipe_reg[g+1].prod) + ROUND_HALF) >> FRAC_BITS;
            end
        end
    end

    always_comb
    begin
        pipe_next[RND] = pipe_reg[RND-1];
        round_up = {pipe_reg[RND-1].rem, 1'b0} >= {2'b00, pipe_reg[RND-1].den};
        if (pipe_reg[RND-1].kind == OP_DIV)
        begin
            pipe_next[RND].mag = mag_t'(pipe_reg[RND-1].num) + mag_t'(round_up);
        end
    end

    always_comb
    begin
        pipe_next[LAST] = pipe_reg[LAST-1];
        if (pipe_reg[LAST-1].kind == OP_MUL ||
            (pipe_reg[LAST-1].kind == OP_DIV && pipe_reg[LAST-1].den != '0))
        begin
            pipe_next[LAST].res = sat_mag(pipe_reg[LAST-1].mag, pipe_reg[LAST-1].neg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= operation.valid;
            for (int k = 1; k <= LAST; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (result.ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (valid_reg[LAST])
        begin
            if (out_valid_reg && !result.ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (result.ready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (valid_reg[LAST])
        begin
            if (out_valid_reg && !result.ready)
            begin
                skid_data_reg <= pipe_reg[LAST].res;
            end
            else
            begin
                out_data_reg <= pipe_reg[LAST].res;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_value = out_data_reg.val;
    assign result.compare_true = out_data_reg.cmp;
    assign result.error_code   = out_data_reg.err;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a result while the output is empty.");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !result.ready |=> skid_valid_reg && out_valid_reg)
        else $error("A stalled result was lost.");

    a_div_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.error_code == ERR_DIV_ZERO |->
            result.result_value == '0 && !result.compare_true)
        else $error("Division by zero gave a nonzero result.");

    a_overflow_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.error_code == ERR_OVERFLOW |->
            result.result_value == WORD_MAX || result.result_value == WORD_MIN)
        else $error("Overflow result is not saturated.");

    a_compare_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.compare_true |->
            result.result_value == '0 && result.error_code == ERR_NONE)
        else $error("Comparison result carries a value or an error.");
endmodule
